@@ sv/reorder_buffer_cumulative_ack_unit_macros.svh @@
// Assertion macros for the reorder buffer unit.
// Used by the top level; no other dependencies.
`ifndef REORDER_BUFFER_CUMULATIVE_ACK_UNIT_MACROS_SVH
`define REORDER_BUFFER_CUMULATIVE_ACK_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RBCA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbca assertion failed");
`define RBCA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbca assertion failed");
`else
`define RBCA_ASSERT_IMP(lbl, ante, cons)
`define RBCA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ sv/rbca_pkg.sv @@
// Types, constants and helpers of the reorder buffer unit.
// No dependencies.
`default_nettype none
package rbca_pkg;
  localparam int SEQ_W = 31;
  localparam int LEN_W = 10;
  localparam int TAG_W = 16;
  localparam int KIND_W = 2;
  localparam int DEPTH_DEF = 16;
  localparam logic [SEQ_W-1:0] START_ACK_RST = 31'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_DELIVER = 2'd0,
    KIND_CUM_ACK = 2'd1,
    KIND_DUP_ACK = 2'd2
  } kind_t;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
    logic             fin;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic             valid;
    kind_t            kind;
    logic [TAG_W-1:0] tag;
    logic [SEQ_W-1:0] ack;
    logic             tend;
    logic             last;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_SH_RD, S_SH_WR, S_INS_WR,
    S_DR_RD, S_DR_CHK, S_ACK
  } state_t;

  // seq + len, saturated at the top of the sequence space
  function automatic logic [SEQ_W-1:0] end_byte(input logic [SEQ_W-1:0] s,
                                                input logic [LEN_W-1:0] l);
    logic [SEQ_W:0] sum;
    sum = {1'b0, s} + {{(SEQ_W+1-LEN_W){1'b0}}, l};
    return sum[SEQ_W] ? {SEQ_W{1'b1}} : sum[SEQ_W-1:0];
  endfunction
endpackage
`default_nettype wire

@@ sv/rbca_store.sv @@
// Reorder store: one write port, one read port, registered read data.
// Depends on rbca_pkg.
`default_nettype none
module rbca_store import rbca_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output entry_t             rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data
);
  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

@@ sv/rbca_ctrl.sv @@
// Sequencer: classifies packets, inserts into the ring-ordered store,
// drains in-order successors and issues results. Depends on rbca_pkg.
`default_nettype none
module rbca_ctrl import rbca_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [SEQ_W-1:0] cfg_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire entry_t           in_item,
  input  wire logic             out_free,
  output res_t                  emit,
  output logic [CW-1:0]         count,
  output logic                  rd_en,
  output logic [AW-1:0]         rd_addr,
  input  wire entry_t           rd_data,
  output logic                  wr_en,
  output logic [AW-1:0]         wr_addr,
  output entry_t                wr_data
);
  state_t st_r, st_nxt;
  logic [SEQ_W-1:0] exp_r, exp_nxt;
  logic done_r, done_nxt;
  logic [AW-1:0] head_r, head_nxt, tail_r, tail_nxt, sp_r, sp_nxt, jp_r, jp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, si_r, si_nxt, pos_r, pos_nxt, j_r, j_nxt;
  entry_t cur_r, cur_nxt;

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] a);
    return (a == AW'(DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction
  function automatic logic [AW-1:0] dec(input logic [AW-1:0] a);
    return (a == '0) ? AW'(DEPTH - 1) : a - 1'b1;
  endfunction

  logic acc, full, rd_lt, rd_eq, dmatch, scan_end, sh_end;
  logic [SEQ_W-1:0] nb;

  assign in_ready = (st_r == S_IDLE) && out_free;
  assign acc      = in_valid && in_ready;
  assign full     = (cnt_r == CW'(DEPTH));
  assign rd_lt    = rd_data.seq < cur_r.seq;
  assign rd_eq    = rd_data.seq == cur_r.seq;
  assign nb       = end_byte(cur_r.seq, cur_r.len);
  assign dmatch   = rd_data.seq == nb;
  assign scan_end = (si_r + 1'b1) == cnt_r;
  assign sh_end   = (j_r - 1'b1) == pos_r;
  assign count    = cnt_r;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (acc && !done_r) begin
          if (in_item.seq > exp_r) begin
            if (full) st_nxt = S_IDLE;
            else if (cnt_r == '0) st_nxt = S_INS_WR;
            else st_nxt = S_SCAN_RD;
          end else if (in_item.seq == exp_r) begin
            st_nxt = S_DR_RD;
          end
        end
      end
      S_SCAN_RD: st_nxt = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (rd_lt) st_nxt = scan_end ? S_INS_WR : S_SCAN_RD;
        else if (rd_eq) st_nxt = S_IDLE;
        else st_nxt = S_SH_RD;
      end
      S_SH_RD: st_nxt = S_SH_WR;
      S_SH_WR: st_nxt = sh_end ? S_INS_WR : S_SH_RD;
      S_INS_WR: st_nxt = S_IDLE;
      S_DR_RD: st_nxt = (cur_r.fin || cnt_r == '0) ? S_ACK : S_DR_CHK;
      S_DR_CHK: begin
        if (!dmatch) st_nxt = S_ACK;
        else if (rd_data.fin || out_free) st_nxt = S_DR_RD;
      end
      S_ACK: if (out_free) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // memory requests and results
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head_r;
    wr_en   = 1'b0;
    wr_addr = jp_r;
    wr_data = cur_r;
    emit    = '0;
    case (st_r)
      S_IDLE: begin
        if (acc && !done_r) begin
          if (in_item.seq > exp_r) begin
            emit.valid = 1'b1;
            emit.kind  = KIND_DUP_ACK;
            emit.ack   = exp_r;
            emit.last  = 1'b1;
          end else if (in_item.seq == exp_r && !in_item.fin) begin
            emit.valid = 1'b1;
            emit.kind  = KIND_DELIVER;
            emit.tag   = in_item.tag;
          end
        end
      end
      S_SCAN_RD: begin
        rd_en   = 1'b1;
        rd_addr = sp_r;
      end
      S_SH_RD: begin
        rd_en   = 1'b1;
        rd_addr = dec(jp_r);
      end
      S_SH_WR: begin
        wr_en   = 1'b1;
        wr_data = rd_data;
      end
      S_INS_WR: wr_en = 1'b1;
      S_DR_RD: rd_en = !(cur_r.fin || cnt_r == '0);
      S_DR_CHK: begin
        if (dmatch && !rd_data.fin && out_free) begin
          emit.valid = 1'b1;
          emit.kind  = KIND_DELIVER;
          emit.tag   = rd_data.tag;
        end
      end
      S_ACK: begin
        emit.valid = out_free;
        emit.kind  = KIND_CUM_ACK;
        emit.ack   = nb;
        emit.tend  = cur_r.fin;
        emit.last  = 1'b1;
      end
      default: ;
    endcase
  end

  // datapath registers
  always_comb begin
    exp_nxt  = exp_r;
    done_nxt = done_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    sp_nxt   = sp_r;
    si_nxt   = si_r;
    pos_nxt  = pos_r;
    jp_nxt   = jp_r;
    j_nxt    = j_r;
    cur_nxt  = cur_r;
    case (st_r)
      S_IDLE: begin
        if (cfg_we) exp_nxt = cfg_data;
        if (acc) begin
          cur_nxt = in_item;
          sp_nxt  = head_r;
          si_nxt  = '0;
          jp_nxt  = tail_r;
        end
      end
      S_SCAN_CHK: begin
        if (rd_lt) begin
          si_nxt = si_r + 1'b1;
          sp_nxt = inc(sp_r);
        end else if (!rd_eq) begin
          pos_nxt = si_r;
          j_nxt   = cnt_r;
        end
      end
      S_SH_WR: begin
        jp_nxt = dec(jp_r);
        j_nxt  = j_r - 1'b1;
      end
      S_INS_WR: begin
        tail_nxt = inc(tail_r);
        cnt_nxt  = cnt_r + 1'b1;
      end
      S_DR_CHK: begin
        if (dmatch && (rd_data.fin || out_free)) begin
          cur_nxt  = rd_data;
          head_nxt = inc(head_r);
          cnt_nxt  = cnt_r - 1'b1;
        end
      end
      S_ACK: begin
        if (out_free) begin
          exp_nxt  = nb;
          done_nxt = done_r | cur_r.fin;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      exp_r  <= START_ACK_RST;
      done_r <= 1'b0;
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      exp_r  <= exp_nxt;
      done_r <= done_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sp_r  <= sp_nxt;
    si_r  <= si_nxt;
    pos_r <= pos_nxt;
    jp_r  <= jp_nxt;
    j_r   <= j_nxt;
    cur_r <= cur_nxt;
  end
endmodule
`default_nettype wire

@@ sv/reorder_buffer_cumulative_ack_unit.sv @@
// Top level of the receiver reorder buffer with cumulative ack.
// Depends on rbca_pkg, rbca_store, rbca_ctrl and the macros header.
`default_nettype none
`include "reorder_buffer_cumulative_ack_unit_macros.svh"
// Takes packet headers and answers with deliver, cumulative-ack and
// duplicate-ack items. Old packets and every packet after the closing one
// give nothing. Early packets go into a ring-ordered store held in one
// single-port-read RAM (head pointer, tail pointer, fill count), sorted by
// sequence number. The sequencer handles a dropped packet in its idle state;
// an early packet takes a read and a check per entry scanned, a read and a
// write per entry shifted up and a final write (none of these when the store
// is full); an in-order packet takes a read and a check per drained entry and
// then the ack (after a read and check of a stored entry that does not
// continue the run, if there is one). Result stalls add to this.
// One output register decouples the result side;
// an item is taken only while that register is free or being emptied.
// Writing cfg_data (start ack) also reloads the expected byte; do it idle.
module reorder_buffer_cumulative_ack_unit import rbca_pkg::*; #(
  parameter int REORDER_DEPTH = DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [30:0] cfg_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // seq_number, payload_length, payload_tag
  input  wire logic        in_tlast,   // end_flag
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // delivered_tag, ack_number, transfer_end
  output logic [1:0]       out_tuser,  // kind
  output logic             out_tlast   // last
);
  localparam int AW = (REORDER_DEPTH > 1) ? $clog2(REORDER_DEPTH) : 1;
  localparam int CW = $clog2(REORDER_DEPTH + 1);

  entry_t in_item, rd_data, wr_data;
  res_t emit;
  logic rd_en, wr_en, out_free;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [CW-1:0] count;

  // payload register of the result side
  logic out_valid_r;
  logic [TAG_W-1:0] o_tag_r;
  logic [SEQ_W-1:0] o_ack_r;
  logic o_tend_r, o_last_r;
  kind_t o_kind_r;

  assign in_item.seq = in_tdata[30:0];
  assign in_item.len = in_tdata[40:31];
  assign in_item.tag = in_tdata[56:41];
  assign in_item.fin = in_tlast;

  assign out_free = !out_valid_r || out_tready;

  rbca_ctrl #(.DEPTH(REORDER_DEPTH), .AW(AW), .CW(CW)) u_ctrl (
    .clk, .rst_n, .cfg_we, .cfg_data,
    .in_valid(in_tvalid), .in_ready(in_tready), .in_item,
    .out_free, .emit, .count,
    .rd_en, .rd_addr, .rd_data, .wr_en, .wr_addr, .wr_data
  );

  rbca_store #(.DEPTH(REORDER_DEPTH), .AW(AW)) u_store (
    .clk, .rd_en, .rd_addr, .rd_data, .wr_en, .wr_addr, .wr_data
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.valid) begin
      out_valid_r <= 1'b1;   // ctrl only emits when the register is free
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      o_kind_r <= emit.kind;
      o_tag_r  <= emit.tag;
      o_ack_r  <= emit.ack;
      o_tend_r <= emit.tend;
      o_last_r <= emit.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {o_tend_r, o_ack_r, o_tag_r};
  assign out_tuser  = o_kind_r;
  assign out_tlast  = o_last_r;

  `RBCA_ASSERT_IMP(a_cnt_bound, 1'b1, count <= CW'(REORDER_DEPTH))
  `RBCA_ASSERT_IMP(a_acc_free, in_tvalid && in_tready, !out_valid_r || out_tready)
  `RBCA_ASSERT_IMP(a_deliver_not_last, out_tvalid && out_tuser == KIND_DELIVER,
                   !out_tlast)
  `RBCA_ASSERT_IMP(a_emit_free, emit.valid, out_free)
endmodule
`default_nettype wire

@@ sim/tb.sv @@
// Testbench for reorder_buffer_cumulative_ack_unit: a clocked driver and monitor
// plus a packet-level predictor of the expected-byte and reorder store state.
// Depends on rbca_pkg and the unit's RTL.
`timescale 1ns / 1ps
module tb import rbca_pkg::*; ();

  localparam int DEPTH = 16;
  localparam int LIMIT = 600000;
  localparam logic [30:0] SEQ_MAX = 31'h7fffffff;

  typedef struct {
    bit [30:0] seq;
    bit [9:0]  len;
    bit        fin;
    bit [15:0] tag;
  } pkt_t;

  typedef struct {
    kind_t     kind;
    bit [15:0] tag;
    bit [30:0] ack;
    bit        tend;
    bit        last;
  } ans_t;

  logic clk = 1'b0, rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [30:0] cfg_data = '0;
  logic in_tvalid = 1'b0, in_tlast = 1'b0;
  logic [63:0] in_tdata = '0;
  logic in_tready, out_tvalid, out_tlast;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0] out_tuser;

  reorder_buffer_cumulative_ack_unit uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  bit [30:0] next_byte = 31'd1;
  bit        xfer_done = 1'b0;
  pkt_t      held[$];
  ans_t      answers[$];
  pkt_t      pending[$];
  pkt_t      cur_pkt;
  int        errors = 0;
  int        cycles = 0;
  int        idle_mode = 0;   // 0 none, 1 sender idles, 2 receiver stalls, 3 both

  function automatic bit [30:0] pkt_end(bit [30:0] s, bit [9:0] l);
    bit [31:0] sum;
    sum = {1'b0, s} + {22'd0, l};
    return sum[31] ? SEQ_MAX : sum[30:0];
  endfunction

  function automatic void push_answer(kind_t k, bit [15:0] t, bit [30:0] a, bit te, bit l);
    ans_t r;
    r.kind = k; r.tag = t; r.ack = a; r.tend = te; r.last = l;
    answers.push_back(r);
  endfunction

  // sorted insert; duplicates and overflow dropped
  function automatic void hold_pkt(pkt_t p);
    int pos;
    pos = 0;
    while (pos < held.size() && held[pos].seq < p.seq) pos++;
    if (pos < held.size() && held[pos].seq == p.seq) return;
    if (held.size() >= DEPTH) return;
    held.insert(pos, p);
  endfunction

  function automatic void take_pkt(pkt_t p);
    pkt_t c;
    bit [30:0] a;
    if (xfer_done || p.seq < next_byte) return;
    if (p.seq > next_byte) begin
      hold_pkt(p);
      push_answer(KIND_DUP_ACK, 16'd0, next_byte, 1'b0, 1'b1);
      return;
    end
    c = p;
    if (!c.fin) push_answer(KIND_DELIVER, c.tag, 31'd0, 1'b0, 1'b0);
    // only the lowest held entry can continue the run
    while (!c.fin && held.size() > 0 && held[0].seq == pkt_end(c.seq, c.len)) begin
      c = held.pop_front();
      if (!c.fin) push_answer(KIND_DELIVER, c.tag, 31'd0, 1'b0, 1'b0);
    end
    a = pkt_end(c.seq, c.len);
    next_byte = a;
    if (c.fin) xfer_done = 1'b1;
    push_answer(KIND_CUM_ACK, 16'd0, a, c.fin, 1'b1);
  endfunction

  function automatic bit draw_idle(int which);
    int pct;
    pct = (idle_mode == which) ? 47 : (idle_mode == 3) ? 6 : 0;
    return $urandom_range(99) < pct;
  endfunction

  // driver: an item moves on in_tvalid && in_tready
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) take_pkt(cur_pkt);
      if (!(in_tvalid && !in_tready)) begin
        if (pending.size() > 0 && !draw_idle(1)) begin
          cur_pkt = pending.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {7'd0, cur_pkt.tag, cur_pkt.len, cur_pkt.seq};
          in_tlast <= cur_pkt.fin;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    ans_t w;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      if (answers.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected item: kind=%0d tdata=%h last=%0d", out_tuser, out_tdata,
                   out_tlast);
      end else begin
        w = answers.pop_front();
        if (out_tuser != w.kind || out_tdata[15:0] != w.tag || out_tdata[46:16] != w.ack ||
            out_tdata[47] != w.tend || out_tlast != w.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp kind=%0d tag=%h ack=%h tend=%0d last=%0d / got kind=%0d tag=%h ack=%h tend=%0d last=%0d",
                     w.kind, w.tag, w.ack, w.tend, w.last, out_tuser, out_tdata[15:0],
                     out_tdata[46:16], out_tdata[47], out_tlast);
        end
      end
    end
    out_tready <= !draw_idle(2);
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic pkt_t mk(bit [30:0] s, bit [9:0] l, bit f, bit [15:0] t);
    pkt_t p;
    p.seq = s; p.len = l; p.fin = f; p.tag = t;
    return p;
  endfunction

  // contiguous run: shuffled early part (may fill the store), head last, then
  // an in-order resend that plugs any hole left by overflow drops
  task automatic queue_run(bit [30:0] base, int n, bit close);
    pkt_t run[$];
    int order[$];
    int j, tmp;
    bit [30:0] s;
    s = base;
    for (int i = 0; i < n; i++) begin
      run.push_back(mk(s, 10'($urandom_range(1, 1023)), 1'b0, 16'($urandom)));
      s = pkt_end(s, run[i].len);
    end
    if (close) run.push_back(mk(s, 10'($urandom_range(1023)), 1'b1, 16'($urandom)));
    for (int i = 1; i < run.size(); i++) order.push_back(i);
    for (int i = order.size() - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i]; order[i] = order[j]; order[j] = tmp;
    end
    foreach (order[i]) begin
      pending.push_back(run[order[i]]);
      if ($urandom_range(5) == 0) pending.push_back(run[order[i]]);  // duplicate
      if (base > 0 && $urandom_range(6) == 0)                         // stale noise
        pending.push_back(mk(31'($urandom_range(0, base - 31'd1)), 10'($urandom),
                             1'($urandom), 16'($urandom)));
    end
    pending.push_back(run[0]);
    foreach (run[i]) pending.push_back(run[i]);
  endtask

  task automatic quiesce();
    while (pending.size() > 0 || in_tvalid || answers.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);  // dropped items give no result; cover a full store walk
  endtask

  task automatic write_start(bit [30:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    next_byte = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    bit [30:0] b;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, start at 100
    idle_mode = 0;
    write_start(31'd100);
    pending.push_back(mk(31'd5, 10'd3, 1'b1, 16'h1234));      // old packet, ignored
    pending.push_back(mk(31'd200, 10'd50, 1'b0, 16'hffff));   // early, stored
    pending.push_back(mk(31'd200, 10'd7, 1'b0, 16'h0001));    // early duplicate
    pending.push_back(mk(31'd100, 10'd100, 1'b0, 16'h0000));  // in order, drains 200
    pending.push_back(mk(31'd250, 10'd0, 1'b0, 16'haaaa));    // zero length
    pending.push_back(mk(31'd250, 10'd1023, 1'b0, 16'h5555));
    queue_run(31'd1273, 18, 1'b0);                            // store full on the way
    quiesce();

    idle_mode = 1;
    write_start(31'd0);
    queue_run(31'd0, 8, 1'b0);
    quiesce();

    idle_mode = 2;
    write_start(SEQ_MAX - 31'd300);
    pending.push_back(mk(SEQ_MAX - 31'd300, 10'd1023, 1'b0, 16'h8001));  // end saturates
    pending.push_back(mk(SEQ_MAX, 10'd5, 1'b0, 16'h7ffe));
    pending.push_back(mk(31'h2aaaaaaa, 10'h2aa, 1'b1, 16'h5a5a));          // old
    for (int i = 0; i < 6; i++)
      pending.push_back(mk(31'($urandom), 10'($urandom), 1'($urandom), 16'($urandom)));
    quiesce();

    idle_mode = 3;
    b = 31'($urandom_range(1000, 31'h3fffffff));
    write_start(b);
    queue_run(b, 6, 1'b0);
    quiesce();

    // closing phase: end packet from the store or in order, then noise
    idle_mode = 1;
    b = 31'($urandom_range(1000, 31'h3fffffff));
    write_start(b);
    if ($urandom_range(1)) begin
      queue_run(b, 8, 1'b1);
    end else begin
      queue_run(b, 8, 1'b0);
      pending.push_back(mk(31'd0, 10'd0, 1'b0, 16'd0));
    end
    quiesce();
    if (!xfer_done) pending.push_back(mk(next_byte, 10'($urandom), 1'b1, 16'($urandom)));
    for (int i = 0; i < 8; i++)
      pending.push_back(mk(31'($urandom), 10'($urandom), 1'($urandom), 16'($urandom)));
    quiesce();

    repeat (200) @(posedge clk);
    errors += answers.size();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
